### rtl/gnod_pkg.sv
// Shared types and constants of the grid nearest-one distance core.
package gnod_pkg;

    localparam int DIST_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CMD_W     = 2;
    localparam int COORD_W   = 6;

    localparam logic [DIST_W-1:0] DIST_MAX   = 7'd127;
    localparam logic [CFG_W-1:0]  SIZE_RESET = 7'd64;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

    // Command codes carried in the input item
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Kind codes of a result item
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;      // write the cell bit of the current input item
        logic rd_issue;     // read the distance store at the input item's cell
        logic run_start;    // clear queue pointers and sweep counter
        logic sweep_step;   // read the next cell bit of the clearing/seeding sweep
        logic pop;          // read the queue head and advance it
        logic expand_step;  // look up the next neighbor of the popped cell
        logic out_load_rd;  // load the output register with a read result
        logic out_load_ack; // load the output register with a run acknowledgement
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic queue_empty;
        logic expand_last;
    } t_ctrl_sts;

endpackage

### rtl/grid_nearest_one_distance_core.sv
// Top level of the grid nearest-one distance core.
//
// Load a binary grid one cell per item, then send a run item: the core gives
// every cell of the configured num_rows x num_cols area its Manhattan
// distance to the nearest cell holding 1 (multi-source breadth-first search,
// 4-connected) and answers with one acknowledgement item. Read items then
// return a cell's distance and a reachable flag; the flag is clear when the
// last run found no 1, when the cell lies outside the configured area, or
// when no run has happened since reset. Loads produce no result. A run
// first sweeps the whole cell store of 2^(clog2(MAX_ROWS)+clog2(MAX_COLS))
// cells (4096 at the defaults), one cell per cycle, clearing the visited
// marks and queueing the sources; then, for each reached cell, it pops the
// queue head, looks up its four neighbors through the single distance-store
// read port and drains, and when the queue is empty it acknowledges.
// The core takes one item at a time; a finished result sits in the output
// register while the next item is accepted, and a read or a run holds its
// result back until that register is free. Size registers may be written
// only while the core is idle.
module grid_nearest_one_distance_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // size registers: index 0 num_rows, index 1 num_cols
    input  logic                             i_cfg_we,
    input  logic [gnod_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gnod_pkg::CFG_W-1:0]       i_cfg_data,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // row[5:0], col[11:6], cell_value[12]
    input  logic [gnod_pkg::CMD_W-1:0]       s_axis_tuser,  // cmd[1:0]
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // distance[6:0], reachable[7]
    output logic                             m_axis_tuser   // kind[0]
);

    gnod_pkg::t_ctrl_cmd               cmd;
    gnod_pkg::t_ctrl_sts               sts;
    logic                              out_kind;
    logic [gnod_pkg::DIST_W-1:0]       out_distance;
    logic                              out_reachable;

    // Sequence loads, reads and the phases of a run; own the handshakes.
    gnod_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Hold the grid, distances and queue; run the sweep and the expansion.
    gnod_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_row        (s_axis_tdata[5:0]),
        .i_col        (s_axis_tdata[11:6]),
        .i_cell_value (s_axis_tdata[12]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_kind       (out_kind),
        .o_distance   (out_distance),
        .o_reachable  (out_reachable)
    );

    assign m_axis_tdata = {out_reachable, out_distance};
    assign m_axis_tuser = out_kind;

endmodule

### rtl/gnod_ram.sv
// Generic simple dual-port RAM with registered read.
module gnod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/gnod_ctrl.sv
// Controller state machine of the grid nearest-one distance core.
module gnod_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [gnod_pkg::CMD_W-1:0]  i_in_cmd,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  gnod_pkg::t_ctrl_sts         i_sts,
    output gnod_pkg::t_ctrl_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SWEEP,
        S_SW_DRAIN,
        S_POP,
        S_EXPAND,
        S_DRAIN,
        S_ACK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_cmd)
                        gnod_pkg::CMD_LOAD: begin
                            o_cmd.load_wr = 1'b1;
                        end
                        gnod_pkg::CMD_RUN: begin
                            o_cmd.run_start = 1'b1;
                            n_state         = S_SWEEP;
                        end
                        gnod_pkg::CMD_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RD_WAIT;
                        end
                        default: begin
                            // drop the unused command
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                if (out_free) begin
                    o_cmd.out_load_rd = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_SW_DRAIN;
                end
            end
            S_SW_DRAIN: begin
                n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.queue_empty) begin
                    n_state = S_ACK;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_EXPAND;
                end
            end
            S_EXPAND: begin
                o_cmd.expand_step = 1'b1;
                if (i_sts.expand_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_POP;
            end
            S_ACK: begin
                if (out_free) begin
                    o_cmd.out_load_ack = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/gnod_dp.sv
// Datapath of the grid nearest-one distance core: size registers, memories, queue, search.
module gnod_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gnod_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gnod_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [gnod_pkg::COORD_W-1:0]     i_row,
    input  logic [gnod_pkg::COORD_W-1:0]     i_col,
    input  logic                             i_cell_value,
    input  gnod_pkg::t_ctrl_cmd              i_cmd,
    output gnod_pkg::t_ctrl_sts              o_sts,
    output logic                             o_kind,
    output logic [gnod_pkg::DIST_W-1:0]      o_distance,
    output logic                             o_reachable
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = gnod_pkg::DIST_W;
    localparam int QW    = DW + AW;

    typedef enum logic [1:0] {
        STEP_RIGHT,
        STEP_LEFT,
        STEP_DOWN,
        STEP_UP
    } t_step;

    // size registers and their saturated values
    logic [gnod_pkg::CFG_W-1:0] r_num_rows;
    logic [gnod_pkg::CFG_W-1:0] r_num_cols;
    logic [gnod_pkg::CFG_W-1:0] nr;
    logic [gnod_pkg::CFG_W-1:0] nc;

    // input cell address
    logic [RW-1:0] in_r;
    logic [CW-1:0] in_c;
    logic          in_store;
    logic          in_area;

    // clearing and seeding sweep
    logic [AW-1:0] r_sw_cnt;
    logic          r_sw_v;
    logic [AW-1:0] r_sw_a;
    logic [RW-1:0] sw_r;
    logic [CW-1:0] sw_c;
    logic          sw_src;
    logic          cell_rd;

    // queue
    logic [AW:0]   r_head;
    logic [AW:0]   r_tail;
    logic [QW-1:0] q_rd;
    logic          q_we;
    logic [QW-1:0] q_wr_data;
    logic [DW-1:0] cur_d;
    logic [RW-1:0] cur_r;
    logic [CW-1:0] cur_c;
    logic [DW-1:0] nd;

    // neighbor expansion
    t_step         r_k;
    logic          n_ok;
    logic [RW-1:0] n_r;
    logic [CW-1:0] n_c;
    logic          r_ck_v;
    logic [AW-1:0] r_ck_a;
    logic          ck_new;

    // distance store: visited mark above the distance
    logic [DW:0]   d_rd;
    logic          d_we;
    logic [AW-1:0] d_wr_addr;
    logic [DW:0]   d_wr_data;
    logic          d_re;
    logic [AW-1:0] d_rd_addr;

    logic          r_ran;
    logic          r_rd_hit;

    logic          r_kind;
    logic [DW-1:0] r_dist;
    logic          r_reach;

    always_comb begin
        nr = r_num_rows;
        if (nr == '0) begin
            nr = gnod_pkg::CFG_W'(1);
        end
        if (int'(nr) > MAX_ROWS) begin
            nr = gnod_pkg::CFG_W'(MAX_ROWS);
        end
        nc = r_num_cols;
        if (nc == '0) begin
            nc = gnod_pkg::CFG_W'(1);
        end
        if (int'(nc) > MAX_COLS) begin
            nc = gnod_pkg::CFG_W'(MAX_COLS);
        end
    end

    assign in_r     = RW'(i_row);
    assign in_c     = CW'(i_col);
    assign in_store = (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign in_area  = (int'(i_row) < int'(nr)) && (int'(i_col) < int'(nc));

    assign sw_r   = r_sw_a[AW-1:CW];
    assign sw_c   = r_sw_a[CW-1:0];
    assign sw_src = r_sw_v && cell_rd
                    && (int'(sw_r) < int'(nr)) && (int'(sw_c) < int'(nc));

    assign cur_d = q_rd[QW-1:AW];
    assign cur_r = q_rd[AW-1:CW];
    assign cur_c = q_rd[CW-1:0];
    assign nd    = (cur_d == gnod_pkg::DIST_MAX) ? gnod_pkg::DIST_MAX : cur_d + DW'(1);

    always_comb begin
        n_r  = cur_r;
        n_c  = cur_c;
        n_ok = 1'b0;
        case (r_k)
            STEP_RIGHT: begin
                n_ok = (int'(cur_c) + 1) < int'(nc);
                n_c  = cur_c + CW'(1);
            end
            STEP_LEFT: begin
                n_ok = cur_c != '0;
                n_c  = cur_c - CW'(1);
            end
            STEP_DOWN: begin
                n_ok = (int'(cur_r) + 1) < int'(nr);
                n_r  = cur_r + RW'(1);
            end
            STEP_UP: begin
                n_ok = cur_r != '0;
                n_r  = cur_r - RW'(1);
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign ck_new = r_ck_v && !d_rd[DW];

    assign d_we      = r_sw_v || ck_new;
    assign d_wr_addr = r_sw_v ? r_sw_a : r_ck_a;
    assign d_wr_data = r_sw_v ? {sw_src, DW'(0)} : {1'b1, nd};
    assign d_re      = i_cmd.rd_issue || (i_cmd.expand_step && n_ok);
    assign d_rd_addr = i_cmd.rd_issue ? {in_r, in_c} : {n_r, n_c};

    assign q_we      = sw_src || ck_new;
    assign q_wr_data = sw_src ? {DW'(0), r_sw_a} : {nd, r_ck_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= gnod_pkg::SIZE_RESET;
            r_num_cols <= gnod_pkg::SIZE_RESET;
            r_sw_cnt   <= '0;
            r_sw_v     <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_k        <= STEP_RIGHT;
            r_ck_v     <= 1'b0;
            r_ran      <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == gnod_pkg::CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == gnod_pkg::CFG_NUM_COLS) begin
                r_num_cols <= i_cfg_data;
            end
            if (i_cmd.run_start) begin
                r_sw_cnt <= '0;
                r_head   <= '0;
                r_tail   <= '0;
                r_ran    <= 1'b1;
            end else begin
                if (i_cmd.sweep_step) begin
                    r_sw_cnt <= r_sw_cnt + AW'(1);
                end
                if (i_cmd.pop) begin
                    r_head <= r_head + (AW + 1)'(1);
                end
                if (q_we) begin
                    r_tail <= r_tail + (AW + 1)'(1);
                end
            end
            r_sw_v <= i_cmd.sweep_step;
            if (i_cmd.pop) begin
                r_k <= STEP_RIGHT;
            end else if (i_cmd.expand_step) begin
                r_k <= t_step'(r_k + 2'd1);
            end
            r_ck_v <= i_cmd.expand_step && n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_a <= r_sw_cnt;
        r_ck_a <= {n_r, n_c};
        if (i_cmd.rd_issue) begin
            r_rd_hit <= r_ran && in_area;
        end
        if (i_cmd.out_load_rd) begin
            r_kind  <= gnod_pkg::KIND_READ;
            r_reach <= r_rd_hit && d_rd[DW];
            r_dist  <= (r_rd_hit && d_rd[DW]) ? d_rd[DW-1:0] : '0;
        end else if (i_cmd.out_load_ack) begin
            r_kind  <= gnod_pkg::KIND_ACK;
            r_reach <= 1'b0;
            r_dist  <= '0;
        end
    end

    gnod_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_wr && in_store),
        .i_wr_addr ({in_r, in_c}),
        .i_wr_data (i_cell_value),
        .i_rd_en   (i_cmd.sweep_step),
        .i_rd_addr (r_sw_cnt),
        .o_rd_data (cell_rd)
    );

    gnod_ram #(
        .WIDTH (DW + 1),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (d_we),
        .i_wr_addr (d_wr_addr),
        .i_wr_data (d_wr_data),
        .i_rd_en   (d_re),
        .i_rd_addr (d_rd_addr),
        .o_rd_data (d_rd)
    );

    gnod_ram #(
        .WIDTH (QW),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_we),
        .i_wr_addr (r_tail[AW-1:0]),
        .i_wr_data (q_wr_data),
        .i_rd_en   (i_cmd.pop),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (q_rd)
    );

    assign o_sts.sweep_last  = &r_sw_cnt;
    assign o_sts.queue_empty = (r_head == r_tail);
    assign o_sts.expand_last = (r_k == STEP_UP);

    assign o_kind      = r_kind;
    assign o_distance  = r_dist;
    assign o_reachable = r_reach;

endmodule
